// File: rtl/utf8d_pkg.sv
// shared types, constants and result helpers for the utf-8 stream decoder
package utf8d_pkg;

   localparam int ByteW = 8;
   localparam int CpW = 21;
   localparam int RawW = 31;
   localparam int UsedW = 3;
   localparam int QueueDepth = 4;
   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
   localparam logic [RawW-1:0] CodeMax = 31'h0010FFFF;
   localparam logic [RawW-1:0] SurrLo = 31'h0000D800;
   localparam logic [RawW-1:0] SurrHi = 31'h0000DFFF;
   localparam logic [15:0] NonCharLo = 16'hFFFE;
   localparam logic [15:0] NonCharHi = 16'hFFFF;

   typedef enum logic [1:0] {
      LEAD_ASCII,
      LEAD_MULTI,
      LEAD_INVALID
   } lead_kind_type;

   typedef struct packed {
      logic [CpW-1:0]   code_point;
      logic [RawW-1:0]  raw_value;
      logic             replaced;
      logic [UsedW-1:0] bytes_used;
      logic             last_result;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [UsedW-1:0] need_len(input logic [RawW-1:0] v);
      logic [UsedW-1:0] n;
      if (v < 31'h80) begin
         n = 3'd1;
      end else if (v < 31'h800) begin
         n = 3'd2;
      end else if (v < 31'h10000) begin
         n = 3'd3;
      end else if (v < 31'h200000) begin
         n = 3'd4;
      end else if (v < 31'h4000000) begin
         n = 3'd5;
      end else begin
         n = 3'd6;
      end
      return n;
   endfunction

   function automatic logic is_bad(input logic [RawW-1:0] v, input logic [UsedW-1:0] len);
      logic bad;
      bad = (v[15:0] == NonCharLo) || (v[15:0] == NonCharHi) || (v == '0) ||
            (v > CodeMax) || ((v >= SurrLo) && (v <= SurrHi)) ||
            (need_len(v) != len);
      return bad;
   endfunction

   function automatic rsp_type done_rsp(input logic [RawW-1:0] v,
                                        input logic [UsedW-1:0] len);
      rsp_type r;
      logic    bad;
      bad = is_bad(v, len);
      r.code_point = bad ? Replacement : v[CpW-1:0];
      r.raw_value = v;
      r.replaced = bad;
      r.bytes_used = len;
      r.last_result = 1'b0;
      return r;
   endfunction

   function automatic rsp_type rep_rsp(input logic [RawW-1:0] raw,
                                       input logic [UsedW-1:0] used);
      rsp_type r;
      r.code_point = Replacement;
      r.raw_value = raw;
      r.replaced = 1'b1;
      r.bytes_used = used;
      r.last_result = 1'b0;
      return r;
   endfunction

endpackage

// File: rtl/utf8d_req_if.sv
// byte channel into the decoder
interface utf8d_req_if;
   import utf8d_pkg::*;

   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;
   logic             buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

// File: rtl/utf8d_rsp_if.sv
// result channel out of the decoder
interface utf8d_rsp_if;
   import utf8d_pkg::*;

   logic             valid;
   logic             ready;
   logic [CpW-1:0]   code_point;
   logic [RawW-1:0]  raw_value;
   logic             replaced;
   logic [UsedW-1:0] bytes_used;
   logic             last_result;

   modport source (output valid, output code_point, output raw_value, output replaced,
                   output bytes_used, output last_result, input ready);
   modport sink (input valid, input code_point, input raw_value, input replaced,
                 input bytes_used, input last_result, output ready);
endinterface

// File: rtl/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder
// Takes one byte per transfer and decodes 1 to 6 byte sequences into code points, giving
// U+FFFD for invalid, broken, truncated, overlong, NUL, surrogate, out-of-range and
// noncharacter input. One byte per cycle is sustained while the result side keeps up and
// the queue has room: the sequence state and all checks sit in one level of logic between
// the state registers and a four-entry result queue. A byte that breaks an open sequence
// gives two results when that byte also ends in a result of its own, else one; req_ch.ready
// is low while fewer than two queue entries are free.
module utf8_stream_decoder (
   input  logic               clock,
   input  logic               reset,
   utf8d_req_if.sink          req_ch,
   utf8d_rsp_if.source        rsp_ch
);
   import utf8d_pkg::*;

   push_type push;
   rsp_type  head;
   logic     accept;
   logic     pop;
   logic     not_empty;
   logic     has_room;

   assign req_ch.ready = has_room;
   assign accept = req_ch.valid & has_room;
   assign pop = not_empty & rsp_ch.ready;

   utf8d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_ch.data_byte),
      .buffer_end (req_ch.buffer_end),
      .push       (push)
   );

   utf8d_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   assign rsp_ch.valid = not_empty;
   assign rsp_ch.code_point = head.code_point;
   assign rsp_ch.raw_value = head.raw_value;
   assign rsp_ch.replaced = head.replaced;
   assign rsp_ch.bytes_used = head.bytes_used;
   assign rsp_ch.last_result = head.last_result;
endmodule

// File: rtl/utf8d_decode.sv
// sequence state and per-byte decode into zero, one or two results
module utf8d_decode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [utf8d_pkg::ByteW-1:0]     data_byte,
   input  logic                            buffer_end,
   output utf8d_pkg::push_type             push
);
   import utf8d_pkg::*;

   logic [RawW-1:0]  pv_ff, pv_in;
   logic [UsedW-1:0] rem_ff, rem_in;
   logic [UsedW-1:0] len_ff, len_in;

   lead_kind_type    lead_kind;
   logic [UsedW-1:0] lead_rem;
   logic [RawW-1:0]  lead_val;
   logic             lead_emit;
   rsp_type          lead_rsp;
   logic [UsedW-1:0] taken;
   logic [RawW-1:0]  cont_val;
   logic [UsedW-1:0] rem_dec;

   always_comb begin
      lead_kind = LEAD_MULTI;
      lead_rem = 3'd0;
      lead_val = '0;
      if (!data_byte[7]) begin
         lead_kind = LEAD_ASCII;
      end else if (data_byte[7:5] == 3'b110) begin
         lead_rem = 3'd1;
         lead_val = {26'b0, data_byte[4:0]};
      end else if (data_byte[7:4] == 4'b1110) begin
         lead_rem = 3'd2;
         lead_val = {27'b0, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
         lead_rem = 3'd3;
         lead_val = {28'b0, data_byte[2:0]};
      end else if (data_byte[7:2] == 6'b111110) begin
         lead_rem = 3'd4;
         lead_val = {29'b0, data_byte[1:0]};
      end else if (data_byte[7:1] == 7'b1111110) begin
         lead_rem = 3'd5;
         lead_val = {30'b0, data_byte[0]};
      end else begin
         lead_kind = LEAD_INVALID;
      end
   end

   always_comb begin
      lead_emit = 1'b1;
      unique case (lead_kind)
         LEAD_ASCII: begin
            lead_rsp = done_rsp({23'b0, data_byte}, 3'd1);
         end
         LEAD_INVALID: begin
            lead_rsp = rep_rsp({23'b0, data_byte}, 3'd1);
         end
         default: begin
            lead_rsp = rep_rsp(lead_val, 3'd1);
            lead_emit = buffer_end;
         end
      endcase
   end

   always_comb begin
      taken = (len_ff > rem_ff) ? len_ff - rem_ff : 3'd1;
      cont_val = {pv_ff[RawW-7:0], data_byte[5:0]};
      rem_dec = rem_ff - 3'd1;

      pv_in = pv_ff;
      rem_in = rem_ff;
      len_in = len_ff;
      push.count = 2'd0;
      push.first = lead_rsp;
      push.second = lead_rsp;

      if (accept) begin
         if (rem_ff == 3'd0) begin
            if (lead_emit) begin
               push.count = 2'd1;
            end else begin
               pv_in = lead_val;
               rem_in = lead_rem;
               len_in = lead_rem + 3'd1;
            end
         end else if (data_byte[7:6] == 2'b10) begin
            pv_in = cont_val;
            rem_in = rem_dec;
            if (rem_dec == 3'd0) begin
               push.count = 2'd1;
               push.first = done_rsp(cont_val, len_ff);
               pv_in = '0;
               len_in = 3'd0;
            end else if (buffer_end) begin
               push.count = 2'd1;
               push.first = rep_rsp(cont_val, taken + 3'd1);
               pv_in = '0;
               rem_in = 3'd0;
               len_in = 3'd0;
            end
         end else begin
            push.first = rep_rsp(pv_ff, taken);
            if (lead_emit) begin
               push.count = 2'd2;
               pv_in = '0;
               rem_in = 3'd0;
               len_in = 3'd0;
            end else begin
               push.count = 2'd1;
               pv_in = lead_val;
               rem_in = lead_rem;
               len_in = lead_rem + 3'd1;
            end
         end
      end

      push.first.last_result = (push.count == 2'd1);
      push.second.last_result = (push.count == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
         rem_ff <= '0;
         len_ff <= '0;
      end else begin
         pv_ff <= pv_in;
         rem_ff <= rem_in;
         len_ff <= len_in;
      end
   end

   // owed bytes always fall short of the sequence length by at least the lead byte
   a_len_covers_rem: assert property (@(posedge clock) disable iff (reset)
      rem_ff != 3'd0 |-> (len_ff > rem_ff) && (len_ff <= 3'd6))
      else $error("sequence length does not cover owed bytes");

   // two results only when an open sequence is broken
   a_two_only_on_break: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> accept && (rem_ff != 3'd0) && (data_byte[7:6] != 2'b10))
      else $error("second result without a broken sequence");

   // buffer end leaves no sequence open
   a_end_flushes: assert property (@(posedge clock) disable iff (reset)
      accept && buffer_end |=> rem_ff == 3'd0)
      else $error("sequence still open after buffer end");

   // nothing is produced without a transfer
   a_no_result_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> push.count == 2'd0)
      else $error("result produced without a transfer");
endmodule

// File: rtl/utf8d_rsp_queue.sv
// small result queue, up to two writes per cycle, one read
module utf8d_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  utf8d_pkg::push_type  push,
   input  logic                 pop,
   output utf8d_pkg::rsp_type   head,
   output logic                 not_empty,
   output logic                 has_room
);
   import utf8d_pkg::*;

   rsp_type         mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_in = wr_ff + PtrW'(push.count);
      rd_in = rd_ff + PtrW'(pop);
      count_in = count_ff + CntW'(push.count) - CntW'(pop);
      head = mem_ff[rd_ff];
      not_empty = (count_ff != '0);
      has_room = (count_ff <= CntW'(QueueDepth - 2));
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + PtrW'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= CntW'(QueueDepth - 2))
      else $error("push into a queue without room");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from an empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      pop && (push.count == 2'd0) |=> count_ff == $past(count_ff) - CntW'(1))
      else $error("count did not drop after a pop");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      PtrW'(wr_ff - rd_ff) == PtrW'(count_ff))
      else $error("pointers disagree with count");
endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for utf8_stream_decoder with its own byte-level decode model
`timescale 1ns / 1ps

module testbench;
   import utf8d_pkg::*;

   logic clock = 1'b0;
   logic reset;

   utf8d_req_if req_ch ();
   utf8d_rsp_if rsp_ch ();

   utf8_stream_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // decoder model state
   logic [RawW-1:0]  acc_value = '0;
   logic [UsedW-1:0] owed_bytes = '0;
   logic [UsedW-1:0] seq_len = '0;

   rsp_type expected_chars[$];

   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned byte_count = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned failures = 0;

   function automatic logic value_rejected(input logic [RawW-1:0] v,
                                           input logic [UsedW-1:0] len);
      logic [UsedW-1:0] min_len;
      if (v[15:0] >= 16'hFFFE || v == '0 || v > 31'h10FFFF ||
          (v >= 31'hD800 && v <= 31'hDFFF)) begin
         return 1'b1;
      end
      if (v < 31'h80) begin
         min_len = 3'd1;
      end else if (v < 31'h800) begin
         min_len = 3'd2;
      end else if (v < 31'h10000) begin
         min_len = 3'd3;
      end else if (v < 31'h200000) begin
         min_len = 3'd4;
      end else if (v < 31'h4000000) begin
         min_len = 3'd5;
      end else begin
         min_len = 3'd6;
      end
      return min_len != len;
   endfunction

   function automatic rsp_type make_char(input logic [RawW-1:0] raw,
                                         input logic bad,
                                         input logic [UsedW-1:0] used);
      rsp_type r;
      r.code_point = bad ? Replacement : raw[CpW-1:0];
      r.raw_value = raw;
      r.replaced = bad;
      r.bytes_used = used;
      r.last_result = 1'b0;
      return r;
   endfunction

   function automatic void clear_state();
      acc_value = '0;
      owed_bytes = '0;
      seq_len = '0;
   endfunction

   function automatic void take_lead(input logic [7:0] b, input logic buf_end,
                                     ref rsp_type out[$]);
      logic [UsedW-1:0] rem;
      logic [RawW-1:0]  val;
      rem = '0;
      val = '0;
      casez (b)
         8'b0???????: begin
            out.push_back(make_char({23'd0, b}, value_rejected({23'd0, b}, 3'd1), 3'd1));
            return;
         end
         8'b110?????: begin
            rem = 3'd1;
            val = RawW'(b[4:0]);
         end
         8'b1110????: begin
            rem = 3'd2;
            val = RawW'(b[3:0]);
         end
         8'b11110???: begin
            rem = 3'd3;
            val = RawW'(b[2:0]);
         end
         8'b111110??: begin
            rem = 3'd4;
            val = RawW'(b[1:0]);
         end
         8'b1111110?: begin
            rem = 3'd5;
            val = RawW'(b[0]);
         end
         default: begin
            out.push_back(make_char({23'd0, b}, 1'b1, 3'd1));
            return;
         end
      endcase
      if (buf_end) begin
         out.push_back(make_char(val, 1'b1, 3'd1));
      end else begin
         acc_value = val;
         owed_bytes = rem;
         seq_len = rem + 3'd1;
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic buf_end);
      rsp_type          out[$];
      logic [UsedW-1:0] taken;
      if (owed_bytes == '0) begin
         take_lead(b, buf_end, out);
      end else begin
         taken = (seq_len > owed_bytes) ? seq_len - owed_bytes : 3'd1;
         if (b[7:6] == 2'b10) begin
            acc_value = {acc_value[RawW-7:0], b[5:0]};
            owed_bytes = owed_bytes - 3'd1;
            taken = taken + 3'd1;
            if (owed_bytes == '0) begin
               out.push_back(make_char(acc_value, value_rejected(acc_value, seq_len), seq_len));
               clear_state();
            end else if (buf_end) begin
               out.push_back(make_char(acc_value, 1'b1, taken));
               clear_state();
            end
         end else begin
            out.push_back(make_char(acc_value, 1'b1, taken));
            clear_state();
            take_lead(b, buf_end, out);
         end
      end
      if (out.size() != 0) begin
         out[out.size()-1].last_result = 1'b1;
      end
      foreach (out[i]) begin
         expected_chars.push_back(out[i]);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic buf_end);
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.buffer_end <= buf_end;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      byte_count++;
      decode_byte(b, buf_end);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
   endtask

   // encode one character, possibly cut short, rejected or pure noise
   task automatic send_random_char();
      logic [RawW-1:0] cp;
      logic [7:0]      lead;
      logic [7:0]      seq[$];
      int unsigned     roll, len, keep;
      roll = $urandom_range(99);
      if (roll >= 90) begin
         send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
         return;
      end
      if (roll < 50) begin
         len = $urandom_range(1, 4);
         case (len)
            1: cp = RawW'($urandom_range(1, 'h7F));
            2: cp = RawW'($urandom_range('h80, 'h7FF));
            3: cp = RawW'($urandom_range('h800, 'hFFFF));
            default: cp = RawW'($urandom_range('h10000, 'h10FFFF));
         endcase
      end else if (roll < 70) begin
         len = $urandom_range(1, 6);
         if (len == 1) begin
            cp = RawW'($urandom_range(0, 'h7F));
         end else begin
            cp = RawW'($urandom & ((32'd1 << (5 * len + 1)) - 1));
         end
      end else if ($urandom_range(1)) begin
         len = 3;
         cp = RawW'('hD800 + $urandom_range(0, 'h7FF));
      end else begin
         cp = RawW'(($urandom_range(0, 16) << 16) | 'hFFFE | $urandom_range(0, 1));
         len = (cp < 'h10000) ? 3 : 4;
      end
      if (len == 1) begin
         seq.push_back(cp[7:0]);
      end else begin
         lead = 8'(~(8'hFF >> len) | ((cp >> (6 * (len - 1))) & (8'hFF >> (len + 1))));
         seq.push_back(lead);
         for (int i = len - 1; i >= 1; i--) begin
            seq.push_back(8'(8'h80 | ((cp >> (6 * (i - 1))) & 8'h3F)));
         end
      end
      keep = len;
      if (len > 1 && $urandom_range(99) < 15) begin
         keep = $urandom_range(1, len - 1);
      end
      for (int i = 0; i < keep; i++) begin
         send_byte(seq[i], (i == keep - 1) && ($urandom_range(7) == 0));
      end
   endtask

   task automatic test_single_bytes();
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();
   endtask

   task automatic test_rejected_values();
      // overlong two-byte form
      send_byte(8'hC1, 1'b0);
      send_byte(8'hBF, 1'b0);
      // surrogate
      send_byte(8'hED, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b0);
      // noncharacter
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // above the code space
      send_byte(8'hF4, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      // six-byte form
      send_byte(8'hFC, 1'b0);
      send_byte(8'h84, 1'b0);
      repeat (4) send_byte(8'h80, 1'b0);
      drain();
   endtask

   task automatic test_broken_and_truncated();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b1);
      send_byte(8'hC3, 1'b1);
      drain();
   endtask

   task automatic test_random(input int unsigned gap, input int unsigned stall,
                              input int unsigned n);
      int unsigned target;
      target = byte_count + n;
      gap_pct = gap;
      stall_pct = stall;
      while (byte_count < target) begin
         send_random_char();
      end
      drain();
   endtask

   task automatic test_backpressure();
      gap_pct = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (40) send_random_char();
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= 90;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic note_failure(input string what, input rsp_type want, input rsp_type got);
      failures++;
      if (failures <= 10) begin
         $write("%s: expected cp=%h raw=%h rep=%b used=%0d last=%b,",
                what, want.code_point, want.raw_value, want.replaced, want.bytes_used,
                want.last_result);
         $display(" got cp=%h raw=%h rep=%b used=%0d last=%b",
                  got.code_point, got.raw_value, got.replaced, got.bytes_used,
                  got.last_result);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.code_point = rsp_ch.code_point;
         got.raw_value = rsp_ch.raw_value;
         got.replaced = rsp_ch.replaced;
         got.bytes_used = rsp_ch.bytes_used;
         got.last_result = rsp_ch.last_result;
         if (expected_chars.size() == 0) begin
            note_failure("unexpected transfer", '0, got);
         end else begin
            want = expected_chars.pop_front();
            if (got.code_point !== want.code_point || got.raw_value !== want.raw_value ||
                got.replaced !== want.replaced || got.bytes_used !== want.bytes_used ||
                got.last_result !== want.last_result) begin
               note_failure("mismatch", want, got);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL utf8_stream_decoder");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.buffer_end <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_bytes();
      test_rejected_values();
      test_broken_and_truncated();
      test_random(0, 0, 425);
      test_random(61, 0, 425);
      test_random(0, 61, 425);
      test_random(21, 21, 425);
      test_backpressure();
      if (failures == 0) begin
         $display("PASS utf8_stream_decoder");
      end else begin
         $display("FAIL utf8_stream_decoder");
      end
      $finish;
   end

endmodule
